FILE: design/pwb_pkg.sv
package pwb_pkg;

  localparam int QW = 32;                 // Q16.16 word
  localparam int FracW = 16;
  localparam int RadW = 31;
  localparam int RestW = 17;
  localparam int DtW = 16;
  localparam int G100W = 39;              // gravity times 100
  localparam int SatInW = 41;
  localparam int HitW = 4;
  localparam int InDataW = 176;
  localparam int OutDataW = 136;

  localparam int unsigned HitBottom = 0;
  localparam int unsigned HitLeft = 1;
  localparam int unsigned HitRight = 2;
  localparam int unsigned HitTop = 3;

  localparam logic [1:0] CfgGravity = 2'd0;
  localparam logic [1:0] CfgTimeStep = 2'd1;
  localparam logic [1:0] CfgRightWall = 2'd2;
  localparam logic [1:0] CfgTopWall = 2'd3;

  localparam logic [DtW-1:0] DtReset = 16'd1092;
  localparam logic [RadW-1:0] RightReset = 31'd52428800;
  localparam logic [RadW-1:0] TopReset = 31'd39321600;

  localparam logic [QW-1:0] QMax = 32'h7fff_ffff;
  localparam logic [QW-1:0] QMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [G100W-1:0] g100;
    logic [DtW-1:0]          time_step;
    logic [RadW-1:0]         right_wall;
    logic [RadW-1:0]         top_wall;
  } cfg_t;

  typedef struct packed {
    logic signed [QW-1:0] pos_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] vel_x;
    logic signed [QW-1:0] vel_y;
    logic [RadW-1:0]      radius;
    logic [RestW-1:0]     restitution;
    logic                 is_circle;
  } particle_t;

  typedef struct packed {
    logic [HitW-1:0]      hit_mask;
    logic signed [QW-1:0] vel_y;
    logic signed [QW-1:0] vel_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] pos_x;
  } result_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [SatInW-1:0] x);
    logic signed [QW-1:0] r;
    if (x[SatInW-1:QW-1] == {(SatInW-QW+1){x[SatInW-1]}}) begin
      r = x[QW-1:0];
    end else if (x[SatInW-1]) begin
      r = QMin;
    end else begin
      r = QMax;
    end
    return r;
  endfunction

  // Takes the product v*e and returns sat32(floor(-v*e / 2^16)).
  function automatic logic signed [QW-1:0] bounce32(input logic signed [49:0] p);
    logic signed [50:0] neg;
    logic signed [50:0] sh;
    neg = -$signed({p[49], p});
    sh = neg >>> FracW;
    return sat32(sh[SatInW-1:0]);
  endfunction

  function automatic logic [33:0] abs34(input logic signed [33:0] x);
    logic [33:0] r;
    if (x[33]) begin
      r = 34'(-x);
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

FILE: design/pwb_integ.sv
module pwb_integ
  import pwb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  particle_t item_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output particle_t item_o
);

  logic signed [48:0] vx_prod_d, vx_prod_q;
  logic signed [55:0] g_prod_d, g_prod_q;
  logic signed [48:0] vy_prod_d, vy_prod_q;
  logic signed [SatInW-1:0] px_sum, vy_sum, py_sum;
  logic [39:0] g_delta;
  particle_t item1_q, item2_d, item2_q, item3_q, item4_d, item4_q;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1: x velocity times dt, and the gravity step.
  assign vx_prod_d = $signed(item_i.vel_x) * $signed({1'b0, cfg_i.time_step});
  assign g_prod_d  = cfg_i.g100 * $signed({1'b0, cfg_i.time_step});

  // Stage 2: move x and add the gravity step to y velocity.
  assign g_delta = g_prod_q[55:16];
  always_comb begin
    px_sum = {{9{item1_q.pos_x[QW-1]}}, item1_q.pos_x}
           + {{8{vx_prod_q[48]}}, vx_prod_q[48:16]};
    vy_sum = {{9{item1_q.vel_y[QW-1]}}, item1_q.vel_y} + {g_delta[39], g_delta};
    item2_d = item1_q;
    item2_d.pos_x = sat32(px_sum);
    item2_d.vel_y = sat32(vy_sum);
  end

  // Stage 3: y velocity, already updated, times dt.
  assign vy_prod_d = $signed(item2_q.vel_y) * $signed({1'b0, cfg_i.time_step});

  // Stage 4: move y.
  always_comb begin
    py_sum = {{9{item3_q.pos_y[QW-1]}}, item3_q.pos_y}
           + {{8{vy_prod_q[48]}}, vy_prod_q[48:16]};
    item4_d = item3_q;
    item4_d.pos_y = sat32(py_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q   <= item_i;
      vx_prod_q <= vx_prod_d;
      g_prod_q  <= g_prod_d;
      item2_q   <= item2_d;
      item3_q   <= item2_q;
      vy_prod_q <= vy_prod_d;
      item4_q   <= item4_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = item4_q;

endmodule

FILE: design/pwb_bounce.sv
module pwb_bounce
  import pwb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  particle_t item_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output result_t   result_o
);

  logic [33:0] abs_x, abs_y, abs_r, abs_t;
  logic [33:0] rad5, rad6;
  logic bot_c, left_c, right_c, top_c;
  logic [HitW-1:0] hit5_d, hit5_q, hit6_d, hit6_q, hit7_q;
  logic signed [49:0] prod_x5_d, prod_x5_q, prod_y5_d, prod_y5_q;
  logic signed [49:0] prod_x7_d, prod_x7_q, prod_y7_d, prod_y7_q;
  particle_t item5_d, item5_q, item6_d, item6_q, item7_q;
  logic v5_q, v6_q, v7_q;

  // Stage 5: bottom and left walls. Contact clamps the coordinate to the
  // radius; the bounce products are formed in parallel from the old velocity.
  assign rad5  = {3'b0, item_i.radius};
  assign abs_y = abs34({{2{item_i.pos_y[QW-1]}}, item_i.pos_y});
  assign abs_x = abs34({{2{item_i.pos_x[QW-1]}}, item_i.pos_x});
  assign bot_c  = item_i.is_circle && (abs_y < rad5);
  assign left_c = item_i.is_circle && (abs_x < rad5);
  assign prod_x5_d = $signed(item_i.vel_x) * $signed({1'b0, item_i.restitution});
  assign prod_y5_d = $signed(item_i.vel_y) * $signed({1'b0, item_i.restitution});

  always_comb begin
    item5_d = item_i;
    hit5_d = '0;
    if (bot_c) begin
      item5_d.pos_y = {1'b0, item_i.radius};
      hit5_d[HitBottom] = item_i.vel_y[QW-1];
    end
    if (left_c) begin
      item5_d.pos_x = {1'b0, item_i.radius};
      hit5_d[HitLeft] = item_i.vel_x[QW-1];
    end
  end

  // Stage 6: apply the first bounce, then test right and top walls against
  // the updated velocity sign.
  assign rad6  = {3'b0, item5_q.radius};
  assign abs_r = abs34($signed({3'b0, cfg_i.right_wall})
                       - $signed({{2{item5_q.pos_x[QW-1]}}, item5_q.pos_x}));
  assign abs_t = abs34($signed({3'b0, cfg_i.top_wall})
                       - $signed({{2{item5_q.pos_y[QW-1]}}, item5_q.pos_y}));
  assign right_c = item5_q.is_circle && (abs_r < rad6);
  assign top_c   = item5_q.is_circle && (abs_t < rad6);

  always_comb begin
    item6_d = item5_q;
    if (hit5_q[HitBottom]) begin
      item6_d.vel_y = bounce32(prod_y5_q);
    end
    if (hit5_q[HitLeft]) begin
      item6_d.vel_x = bounce32(prod_x5_q);
    end
    hit6_d = hit5_q;
    hit6_d[HitRight] = right_c && !item6_d.vel_x[QW-1] && (item6_d.vel_x != '0);
    hit6_d[HitTop]   = top_c && !item6_d.vel_y[QW-1] && (item6_d.vel_y != '0);
  end

  // Stage 7: products for the second bounce.
  assign prod_x7_d = $signed(item6_q.vel_x) * $signed({1'b0, item6_q.restitution});
  assign prod_y7_d = $signed(item6_q.vel_y) * $signed({1'b0, item6_q.restitution});

  // Final: apply the right and top bounces on the way into the output queue.
  always_comb begin
    result_o.pos_x = item7_q.pos_x;
    result_o.pos_y = item7_q.pos_y;
    result_o.vel_x = hit7_q[HitRight] ? bounce32(prod_x7_q) : item7_q.vel_x;
    result_o.vel_y = hit7_q[HitTop] ? bounce32(prod_y7_q) : item7_q.vel_y;
    result_o.hit_mask = hit7_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item5_q   <= item5_d;
      hit5_q    <= hit5_d;
      prod_x5_q <= prod_x5_d;
      prod_y5_q <= prod_y5_d;
      item6_q   <= item6_d;
      hit6_q    <= hit6_d;
      item7_q   <= item6_q;
      hit7_q    <= hit6_q;
      prod_x7_q <= prod_x7_d;
      prod_y7_q <= prod_y7_d;
    end
  end

  assign valid_o = v7_q;

  // A bottom bounce leaves y at the radius, since the top wall never moves it.
  a_bottom_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && hit7_q[HitBottom] |-> item7_q.pos_y == {1'b0, item7_q.radius})
    else $error("bottom bounce without clamp");

  a_left_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && hit7_q[HitLeft] |-> item7_q.pos_x == {1'b0, item7_q.radius})
    else $error("left bounce without clamp");

  a_no_hits_off_circle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !item7_q.is_circle |-> hit7_q == '0)
    else $error("wall hit on a non-circle");

  a_left_then_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && hit7_q[HitLeft] && hit7_q[HitRight] |-> !item7_q.vel_x[QW-1])
    else $error("right bounce after left bounce with negative velocity");

endmodule

FILE: design/pwb_ofifo.sv
module pwb_ofifo
  import pwb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    pop_ready_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    room_o
);

  result_t mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic pop;

  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q != 2'd2);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The pipeline only advances while there is room, so a push never finds
  // the queue full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push into full output queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue count out of range");

  a_ptrs_track_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

FILE: design/particle_integrate_wall_bounce_core.sv
// Channel   Dir  Handshake        tdata (lowest bit first)                     tuser
// s_axis    in   tvalid/tready    pos_x, pos_y, vel_x, vel_y, radius,          is_circle
//                                 restitution (176 bits)
// m_axis    out  tvalid/tready    new_pos_x, new_pos_y, new_vel_x, new_vel_y,  -
//                                 hit_mask, 4 zero bits (136 bits)
// cfg       in   cfg_we_i         cfg_addr_i selects the register, cfg_wdata_i is the value
//
// One request per cycle is taken while the output queue has room; each request
// passes seven pipeline stages and then the two-entry output queue. Reset
// clears the stage valid bits and the queue and loads the default gravity,
// step and wall registers. When the queue is full the whole pipeline holds;
// s_axis_tready follows the queue's free space only.
module particle_integrate_wall_bounce_core
  import pwb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y, radius, restitution
  input  logic                s_axis_tuser,   // is_circle
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                                              // hit_mask, zero fill
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [QW-1:0]       cfg_wdata_i
);

  cfg_t cfg_q;
  particle_t in_item, mid_item;
  result_t res, out_res;
  logic en, mid_valid, res_valid;
  logic signed [G100W-1:0] g_ext;

  // Gravity is stored already multiplied by 100 (64 + 32 + 4).
  assign g_ext = {{(G100W-QW){cfg_wdata_i[QW-1]}}, cfg_wdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.g100       <= '0;
      cfg_q.time_step  <= DtReset;
      cfg_q.right_wall <= RightReset;
      cfg_q.top_wall   <= TopReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgGravity:   cfg_q.g100 <= (g_ext <<< 6) + (g_ext <<< 5) + (g_ext <<< 2);
        CfgTimeStep:  cfg_q.time_step <= cfg_wdata_i[DtW-1:0];
        CfgRightWall: cfg_q.right_wall <= cfg_wdata_i[RadW-1:0];
        CfgTopWall:   cfg_q.top_wall <= cfg_wdata_i[RadW-1:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready = en;

  always_comb begin
    in_item.pos_x       = s_axis_tdata[31:0];
    in_item.pos_y       = s_axis_tdata[63:32];
    in_item.vel_x       = s_axis_tdata[95:64];
    in_item.vel_y       = s_axis_tdata[127:96];
    in_item.radius      = s_axis_tdata[158:128];
    in_item.restitution = s_axis_tdata[175:159];
    in_item.is_circle   = s_axis_tuser;
  end

  pwb_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .cfg_i   (cfg_q),
    .valid_o (mid_valid),
    .item_o  (mid_item)
  );

  pwb_bounce u_bounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (mid_valid),
    .item_i   (mid_item),
    .cfg_i    (cfg_q),
    .valid_o  (res_valid),
    .result_o (res)
  );

  pwb_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && res_valid),
    .data_i      (res),
    .pop_ready_i (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .room_o      (en)
  );

  assign m_axis_tdata = {{(OutDataW-4*QW-HitW){1'b0}}, out_res};

endmodule
